### design/wfb_pkg.sv
// wfb_pkg: shared types, frame constants and the symbol encoder of the wind frame builder
// no dependencies; imported by every module of the block
`default_nettype none

package wfb_pkg;

    // frame layout
    localparam int unsigned FRAME_BYTES = 13;
    localparam logic [3:0]  IDX_SYNC    = 4'd3;
    localparam logic [3:0]  IDX_ID      = 4'd4;
    localparam logic [3:0]  IDX_CHAN    = 4'd5;
    localparam logic [3:0]  IDX_ROLL    = 4'd6;
    localparam logic [3:0]  IDX_BATT    = 4'd7;
    localparam logic [3:0]  IDX_ZERO    = 4'd8;
    localparam logic [3:0]  IDX_WIND0   = 4'd9;
    localparam logic [3:0]  IDX_WIND1   = 4'd10;
    localparam logic [3:0]  IDX_WIND2   = 4'd11;
    localparam logic [3:0]  IDX_LAST    = 4'(FRAME_BYTES - 1);

    // fixed byte values
    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_BYTE     = 8'hA1;
    localparam logic [7:0] ID_BYTE       = 8'h98;
    localparam logic [3:0] CHAN_HI       = 4'h4;
    localparam logic [7:0] BATT_LOW_FLAG = 8'h40;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;

    // nibble sum of the fixed parts: low nibble of sync, id byte, high nibble of channel byte
    localparam logic [7:0] CSUM_BASE = 8'(SYNC_BYTE[3:0]) + 8'(ID_BYTE[7:4])
                                     + 8'(ID_BYTE[3:0]) + 8'(CHAN_HI);

    // readings
    localparam logic [9:0] MAX_READING = 10'd999;

    // configuration register indexes
    localparam logic [1:0] CFG_ROLLING_CODE = 2'd0;
    localparam logic [1:0] CFG_CHANNEL      = 2'd1;

    typedef struct packed {
        logic [7:0] rolling_code;
        logic [3:0] channel;
    } t_cfg;

    // one reading after clamping, with its quotients by ten and by a hundred
    typedef struct packed {
        logic [9:0] gust;
        logic [6:0] gust_div10;
        logic [3:0] gust_div100;
        logic [9:0] avg;
        logic [6:0] avg_div10;
        logic [3:0] avg_div100;
        logic       battery_ok;
    } t_reading;

    // bits sent 4..7 then 0..3, 1 -> 10, 0 -> 01, first pair in the top bits
    function automatic logic [15:0] f_manchester(input logic [7:0] b);
        logic [15:0] w;
        logic [2:0]  pos;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            pos = 3'(k + 4);
            w   = {w[13:0], (b[pos] ? 2'b10 : 2'b01)};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### design/wfb_front.sv
// wfb_front: input stage, clamps a reading and splits it by reciprocal multiplication
// depends on wfb_pkg
`default_nettype none

module wfb_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [9:0]        i_gust,
    input  wire logic [9:0]        i_avg_wind,
    input  wire logic              i_battery_ok,
    output logic                   o_push_valid,
    input  wire logic              i_push_ready,
    output wfb_pkg::t_reading      o_push_data
);
    import wfb_pkg::*;

    logic       r_valid;
    t_reading   r_entry;
    t_reading   n_entry;
    logic [9:0] w_gust;
    logic [9:0] w_avg;
    logic [17:0] w_gust_p10;
    logic [17:0] w_avg_p10;
    logic [15:0] w_gust_p100;
    logic [15:0] w_avg_p100;

    // saturate readings
    assign w_gust = (i_gust > MAX_READING) ? MAX_READING : i_gust;
    assign w_avg  = (i_avg_wind > MAX_READING) ? MAX_READING : i_avg_wind;

    // v/10 = (v*205)>>11 and v/100 = (v*41)>>12, exact below 1000
    assign w_gust_p10  = 18'(w_gust) * 18'd205;
    assign w_avg_p10   = 18'(w_avg) * 18'd205;
    assign w_gust_p100 = 16'(w_gust) * 16'd41;
    assign w_avg_p100  = 16'(w_avg) * 16'd41;

    always_comb begin
        n_entry.gust        = w_gust;
        n_entry.gust_div10  = w_gust_p10[17:11];
        n_entry.gust_div100 = w_gust_p100[15:12];
        n_entry.avg         = w_avg;
        n_entry.avg_div10   = w_avg_p10[17:11];
        n_entry.avg_div100  = w_avg_p100[15:12];
        n_entry.battery_ok  = i_battery_ok;
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_entry;

    // holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

### design/wfb_queue.sv
// wfb_queue: short fifo of readings between the input stage and the frame sequencer
// depends on wfb_pkg
`default_nettype none

module wfb_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire wfb_pkg::t_reading i_push_data,
    output logic                   o_pop_valid,
    input  wire logic              i_pop,
    output wfb_pkg::t_reading      o_pop_data
);
    import wfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_reading         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_cnt != FULL_CNT);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/wfb_back.sv
// wfb_back: frame sequencer, turns one queued reading into thirteen frame bytes
// depends on wfb_pkg
`default_nettype none

module wfb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wfb_pkg::t_cfg     i_cfg,
    input  wire logic              i_pop_valid,
    output logic                   o_pop,
    input  wire wfb_pkg::t_reading i_pop_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_packet_byte,
    output logic [3:0]             o_byte_index,
    output logic [15:0]            o_symbol_word,
    output logic                   o_last
);
    import wfb_pkg::*;

    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_out_valid;

    // current frame digits
    logic [3:0] r_g1, r_g10, r_g100, r_a1, r_a10, r_a100;
    logic       r_batt_ok;

    logic [9:0] w_g1_full, w_a1_full;
    logic [6:0] w_g10_full, w_a10_full;
    logic       w_adv;
    logic       w_load;
    logic [7:0] w_sum;
    logic [7:0] w_byte;

    assign w_adv  = !r_out_valid || i_out_ready;
    assign w_load = i_pop_valid && (!r_busy || (w_adv && r_idx == IDX_LAST));
    assign o_pop  = w_load;

    // digits from the quotients
    assign w_g1_full  = i_pop_data.gust - 10'(i_pop_data.gust_div10) * 10'd10;
    assign w_a1_full  = i_pop_data.avg - 10'(i_pop_data.avg_div10) * 10'd10;
    assign w_g10_full = i_pop_data.gust_div10 - 7'(i_pop_data.gust_div100) * 7'd10;
    assign w_a10_full = i_pop_data.avg_div10 - 7'(i_pop_data.avg_div100) * 7'd10;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_g1      <= w_g1_full[3:0];
            r_g10     <= w_g10_full[3:0];
            r_g100    <= i_pop_data.gust_div100;
            r_a1      <= w_a1_full[3:0];
            r_a10     <= w_a10_full[3:0];
            r_a100    <= i_pop_data.avg_div100;
            r_batt_ok <= i_pop_data.battery_ok;
        end
    end

    // nibble checksum over the low nibble of byte 3 and both nibbles of bytes 4 to 11
    assign w_sum = CSUM_BASE + 8'(i_cfg.channel)
                 + 8'(i_cfg.rolling_code[7:4]) + 8'(i_cfg.rolling_code[3:0])
                 + (r_batt_ok ? 8'd0 : 8'(BATT_LOW_FLAG[7:4]))
                 + 8'(r_g1) + 8'(r_g10) + 8'(r_g100)
                 + 8'(r_a1) + 8'(r_a10) + 8'(r_a100);

    // byte select by position
    always_comb begin
        case (r_idx)
            IDX_SYNC:  w_byte = SYNC_BYTE;
            IDX_ID:    w_byte = ID_BYTE;
            IDX_CHAN:  w_byte = {CHAN_HI, i_cfg.channel};
            IDX_ROLL:  w_byte = i_cfg.rolling_code;
            IDX_BATT:  w_byte = r_batt_ok ? ZERO_BYTE : BATT_LOW_FLAG;
            IDX_ZERO:  w_byte = ZERO_BYTE;
            IDX_WIND0: w_byte = {r_g1, r_g10};
            IDX_WIND1: w_byte = {r_g100, r_a1};
            IDX_WIND2: w_byte = {r_a10, r_a100};
            IDX_LAST:  w_byte = {w_sum[3:0], w_sum[7:4]};
            default:   w_byte = PREAMBLE_BYTE;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (!r_busy) begin
                if (w_load) begin
                    r_busy <= 1'b1;
                    r_idx  <= '0;
                end
            end else if (w_adv) begin
                if (r_idx == IDX_LAST) begin
                    r_busy <= w_load;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            o_packet_byte <= w_byte;
            o_byte_index  <= r_idx;
            o_symbol_word <= f_manchester(w_byte);
            o_last        <= (r_idx == IDX_LAST);
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_last == (o_byte_index == IDX_LAST)))
        else $error("last mark does not match byte position");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_byte_index <= IDX_LAST))
        else $error("byte position beyond frame");

    a_next_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !o_last) |=>
            (r_out_valid && o_byte_index == 4'($past(o_byte_index) + 4'd1)))
        else $error("frame bytes not back to back in order");

    a_busy_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0))
        else $error("position counter left set while idle");

endmodule

`default_nettype wire

### design/wind_frame_builder_manchester.sv
// wind_frame_builder_manchester: top level, configuration registers and the three stages
// depends on wfb_pkg, wfb_front, wfb_queue, wfb_back
//
// Usage: one wind reading (gust, avg_wind, battery_ok) is a transfer on the input
// channel (i_in_valid / o_in_ready). It becomes a 13-byte radio frame sent as 13
// transfers on the output channel (o_out_valid / i_out_ready), one per frame byte,
// each with the raw byte, its position, its Manchester symbol word and a last mark
// on the checksum byte.
// Path: a reading passes the input stage's holding register, the reading queue and
// the frame sequencer before its first byte leaves the output register. Throughput:
// one byte per cycle while i_out_ready is high; the frame sequencer's byte counter
// limits how fast readings go through. The input stage and the reading queue
// (QUEUE_DEPTH entries) keep taking readings while a frame is still going out.
// Configuration: i_cfg_we writes rolling_code (index 0) or channel (index 1) from
// i_cfg_data; other indexes are ignored. Write only while no frame is pending.
// Reset: synchronous, active low; clears all valids, empties the queue and sets
// rolling_code to 1 and channel to 0.
// Stall: when i_out_ready is low the current byte holds; the queue fills and then
// o_in_ready drops until bytes move again.
`default_nettype none

module wind_frame_builder_manchester #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [9:0]  i_gust,
    input  wire logic [9:0]  i_avg_wind,
    input  wire logic        i_battery_ok,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_packet_byte,
    output logic [3:0]       o_byte_index,
    output logic [15:0]      o_symbol_word,
    output logic             o_last
);
    import wfb_pkg::*;

    t_cfg     r_cfg;
    logic     w_push_valid;
    logic     w_push_ready;
    t_reading w_push_data;
    logic     w_pop_valid;
    logic     w_pop;
    t_reading w_pop_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rolling_code <= 8'd1;
            r_cfg.channel      <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROLLING_CODE: r_cfg.rolling_code <= i_cfg_data;
                CFG_CHANNEL:      r_cfg.channel      <= i_cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // input stage
    wfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_gust       (i_gust),
        .i_avg_wind   (i_avg_wind),
        .i_battery_ok (i_battery_ok),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // reading queue
    wfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_data   (w_pop_data)
    );

    // frame sequencer
    wfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_pop_valid   (w_pop_valid),
        .o_pop         (w_pop),
        .i_pop_data    (w_pop_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packet_byte (o_packet_byte),
        .o_byte_index  (o_byte_index),
        .o_symbol_word (o_symbol_word),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

### test/wind_frame_builder_manchester_test.sv
// wind_frame_builder_manchester_test: self-checking bench for the wind frame builder
// depends on wfb_pkg and wind_frame_builder_manchester; drives readings with bursty
// input traffic and a stalling receiver, and checks every frame byte against its own predictor
`default_nettype none

module wind_frame_builder_manchester_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DIRECTED_ROWS  = 13;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 75;
    localparam int MAX_REPORTS    = 10;

    // indexes that map to no register
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_LONG_STALLS} t_rx_mode;

    // one expected frame byte
    typedef struct packed {
        logic [7:0]  packet_byte;
        logic [3:0]  byte_index;
        logic [15:0] symbol_word;
        logic        last;
    } t_frame_byte;

    // directed row: reading plus optional hand-computed bytes 9..12
    typedef struct packed {
        logic [9:0]  gust;
        logic [9:0]  avg_wind;
        logic        battery_ok;
        logic        typed;
        logic [31:0] tail;
    } t_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_index  = '0;
    logic [7:0]  i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic [9:0]  i_gust       = '0;
    logic [9:0]  i_avg_wind   = '0;
    logic        i_battery_ok = 1'b0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_packet_byte;
    logic [3:0]  o_byte_index;
    logic [15:0] o_symbol_word;
    logic        o_last;

    // bench side of the current reading: hand-computed tail, if any
    logic        row_typed = 1'b0;
    logic [31:0] row_tail  = '0;

    // bench copy of the configuration registers
    logic [7:0] model_roll = 8'd1;
    logic [3:0] model_chan = 4'd0;

    t_frame_byte frame_bytes_q[$];
    t_row        dir_rows[DIRECTED_ROWS];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          burst_left     = 0;
    logic        steady_phase   = 1'b0;

    t_rx_mode    rx_mode    = RX_STEADY;
    int          mode_left  = 0;
    int          stall_left = 0;

    wind_frame_builder_manchester uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_gust        (i_gust),
        .i_avg_wind    (i_avg_wind),
        .i_battery_ok  (i_battery_ok),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packet_byte (o_packet_byte),
        .o_byte_index  (o_byte_index),
        .o_symbol_word (o_symbol_word),
        .o_last        (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // half-bit pairs, bit 4 first through bit 7, then bit 0 through bit 3
    function automatic logic [15:0] manchester_pairs(input logic [7:0] b);
        logic [15:0] w;
        int          src;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            src = (i < 4) ? i + 4 : i - 4;
            w[15 - 2 * i -: 2] = b[src] ? 2'b10 : 2'b01;
        end
        return w;
    endfunction

    // whole frame for one reading under the given configuration
    function automatic logic [12:0][7:0] predict_frame(input logic [9:0] g_raw,
                                                       input logic [9:0] a_raw,
                                                       input logic batt_ok,
                                                       input logic [7:0] roll,
                                                       input logic [3:0] chan);
        logic [12:0][7:0] fb;
        int unsigned      g;
        int unsigned      a;
        logic [7:0]       sum;
        g  = (g_raw > MAX_READING) ? MAX_READING : g_raw;
        a  = (a_raw > MAX_READING) ? MAX_READING : a_raw;
        fb[0]  = PREAMBLE_BYTE;
        fb[1]  = PREAMBLE_BYTE;
        fb[2]  = PREAMBLE_BYTE;
        fb[3]  = SYNC_BYTE;
        fb[4]  = ID_BYTE;
        fb[5]  = {CHAN_HI, chan};
        fb[6]  = roll;
        fb[7]  = batt_ok ? ZERO_BYTE : BATT_LOW_FLAG;
        fb[8]  = ZERO_BYTE;
        fb[9]  = {4'(g % 10), 4'((g / 10) % 10)};
        fb[10] = {4'((g / 100) % 10), 4'(a % 10)};
        fb[11] = {4'((a / 10) % 10), 4'((a / 100) % 10)};
        sum = 8'(fb[3][3:0]);
        for (int i = 4; i < 12; i++)
            sum = sum + 8'(fb[i][7:4]) + 8'(fb[i][3:0]);
        fb[12] = {sum[3:0], sum[7:4]};
        return fb;
    endfunction

    // reading in the usual range most of the time, extremes and saturation now and then
    function automatic logic [9:0] random_reading();
        case ($urandom_range(0, 19))
            0: begin
                return 10'd0;
            end
            1: begin
                return MAX_READING;
            end
            2, 3: begin
                return 10'($urandom_range(1000, 1023));
            end
            default: begin
                return 10'($urandom_range(0, 999));
            end
        endcase
    endfunction

    // one reading transfer, with a random gap at the start of each burst outside the steady phase
    task automatic send_reading(input logic [9:0] g, input logic [9:0] a, input logic b,
                                input logic typed, input logic [31:0] tail);
        if (burst_left == 0) begin
            if (!steady_phase) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_gust       <= g;
        i_avg_wind   <= a;
        i_battery_ok <= b;
        row_typed    <= typed;
        row_tail     <= tail;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding frame byte
    task automatic wait_frames_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_bytes_q.size() != 0) @(posedge i_clk);
    endtask

    // both registers, then a write to an unused index that must be ignored
    task automatic program_config(input logic [7:0] roll, input logic [7:0] chan_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROLLING_CODE;
        i_cfg_data  <= roll;
        @(posedge i_clk);
        model_roll = roll;
        i_cfg_index <= CFG_CHANNEL;
        i_cfg_data  <= chan_data;
        @(posedge i_clk);
        model_chan = chan_data[3:0];
        i_cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3;
        i_cfg_data  <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // expected bytes for each accepted reading
    always @(posedge i_clk) begin : frame_predict
        logic [12:0][7:0] fb;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            fb = predict_frame(i_gust, i_avg_wind, i_battery_ok, model_roll, model_chan);
            if (row_typed) begin
                fb[9]  = row_tail[31:24];
                fb[10] = row_tail[23:16];
                fb[11] = row_tail[15:8];
                fb[12] = row_tail[7:0];
            end
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_bytes_q.push_back('{fb[i], 4'(i), manchester_pairs(fb[i]),
                                          4'(i) == IDX_LAST});
        end
    end

    // compare each output transfer with the oldest expected byte
    always @(posedge i_clk) begin : frame_check
        t_frame_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_bytes_q.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected byte: byte %h index %0d symbols %h last %b",
                             o_packet_byte, o_byte_index, o_symbol_word, o_last);
                mismatch_count++;
            end else begin
                want = frame_bytes_q.pop_front();
                if (o_packet_byte !== want.packet_byte || o_byte_index !== want.byte_index ||
                    o_symbol_word !== want.symbol_word || o_last !== want.last) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: expected byte %h index %0d symbols %h last %b, %s",
                                 want.packet_byte, want.byte_index, want.symbol_word,
                                 want.last, $sformatf("got byte %h index %0d symbols %h last %b",
                                 o_packet_byte, o_byte_index, o_symbol_word, o_last));
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: switches among steady, choppy and long-stall patterns
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 2));
            mode_left <= $urandom_range(150, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            case (rx_mode)
                RX_STEADY: begin
                    i_out_ready <= 1'b1;
                end
                RX_CHOPPY: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        i_out_ready <= 1'b0;
                        stall_left  <= $urandom_range(1, 30);
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // watchdog on cycles with no transfer on either channel and no configuration write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("wind_frame_builder_manchester_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus: directed rows at reset configuration, then random phases
    initial begin : stimulus
        logic [9:0] g;
        logic [9:0] a;

        // typed tails assume rolling code 1 and channel 0
        dir_rows[0]  = '{10'd0,    10'd0,    1'b1, 1'b1, 32'h0000_0071};
        dir_rows[1]  = '{10'd999,  10'd999,  1'b0, 1'b1, 32'h9999_9915};
        dir_rows[2]  = '{10'd1023, 10'd1023, 1'b1, 1'b1, 32'h9999_99D4};
        dir_rows[3]  = '{10'd1000, 10'd0,    1'b1, 1'b1, 32'h9990_0023};
        dir_rows[4]  = '{10'd0,    10'd1000, 1'b0, 1'b1, 32'h0009_9963};
        dir_rows[5]  = '{10'd123,  10'd456,  1'b1, 1'b0, 32'h0};
        dir_rows[6]  = '{10'd456,  10'd123,  1'b0, 1'b0, 32'h0};
        dir_rows[7]  = '{10'd9,    10'd90,   1'b1, 1'b0, 32'h0};
        dir_rows[8]  = '{10'd100,  10'd10,   1'b0, 1'b0, 32'h0};
        dir_rows[9]  = '{10'd512,  10'd511,  1'b1, 1'b0, 32'h0};
        dir_rows[10] = '{10'd998,  10'd1,    1'b0, 1'b0, 32'h0};
        dir_rows[11] = '{10'd1001, 10'd1022, 1'b1, 1'b0, 32'h0};
        dir_rows[12] = '{10'd341,  10'd682,  1'b0, 1'b0, 32'h0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_reading(dir_rows[r].gust, dir_rows[r].avg_wind, dir_rows[r].battery_ok,
                         dir_rows[r].typed, dir_rows[r].tail);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // registers change only with no frame in flight
            wait_frames_done();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (phase)
                0: begin
                    program_config(8'h00, 8'h00);
                end
                1: begin
                    program_config(8'hFF, 8'hFF);
                end
                2: begin
                    program_config(8'h01, 8'hF0);
                end
                default: begin
                    program_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            endcase
            steady_phase = (phase == 3);
            burst_left   = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                g = random_reading();
                a = random_reading();
                send_reading(g, a, 1'($urandom_range(0, 1)), 1'b0, 32'h0);
            end
        end

        wait_frames_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && frame_bytes_q.size() == 0) begin
            $display("wind_frame_builder_manchester_test passed");
        end else begin
            $display("wind_frame_builder_manchester_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/wfb_pkg.sv
design/wfb_front.sv
design/wfb_queue.sv
design/wfb_back.sv
design/wind_frame_builder_manchester.sv
test/wind_frame_builder_manchester_test.sv
